FILE: sv/tbd_pkg.sv
// ----------------------------------------------------------------------------
// tbd_pkg: shared types and keyword ROM for the BASIC detokenizer
// Keyword lookup is a constant function over table select and index.
// ----------------------------------------------------------------------------
package tbd_pkg;

    typedef enum logic [1:0] {
        MODE_DATA   = 2'd0,
        MODE_NUMBER = 2'd1,
        MODE_LENGTH = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        TBL_MAIN = 2'd0,
        TBL_FN   = 2'd1,
        TBL_CMD  = 2'd2,
        TBL_STMT = 2'd3
    } t_table;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_DIGITS = 2'd1,
        ST_NUMBER = 2'd2,
        ST_WORD   = 2'd3
    } t_state;

    localparam logic [7:0] BYTE_NEWLINE  = 8'h0D;
    localparam logic [7:0] BYTE_LINENUM  = 8'h8D;
    localparam logic [7:0] BYTE_QUOTE    = 8'h22;
    localparam logic [7:0] BYTE_ESC_FN   = 8'hC6;
    localparam logic [7:0] BYTE_ESC_CMD  = 8'hC7;
    localparam logic [7:0] BYTE_ESC_STMT = 8'hC8;
    localparam logic [7:0] MAIN_BASE     = 8'h80;
    localparam logic [7:0] ESC_BASE      = 8'h8E;
    localparam int NUM_WIDTH = 5;
    localparam int MAX_KW    = 8;

    typedef struct packed {
        logic [3:0]  len;
        logic [63:0] text;  // first character in bits 63:56
    } t_kw;

    function automatic t_kw kw(input string s);
        t_kw r;
        r.len  = 4'(s.len());
        r.text = '0;
        for (int i = 0; i < MAX_KW; i++) begin
            if (i < s.len()) r.text[63-8*i -: 8] = s[i];
        end
        return r;
    endfunction

    function automatic t_kw main_kw(input logic [6:0] i);
        case (i)
            7'd0: return kw("AND");       7'd1: return kw("DIV");
            7'd2: return kw("EOR");       7'd3: return kw("MOD");
            7'd4: return kw("OR");        7'd5: return kw("ERROR");
            7'd6: return kw("LINE");      7'd7: return kw("OFF");
            7'd8: return kw("STEP");      7'd9: return kw("SPC");
            7'd10: return kw("TAB(");     7'd11: return kw("ELSE");
            7'd12: return kw("THEN");     7'd14: return kw("OPENIN");
            7'd15: return kw("PTR");      7'd16: return kw("PAGE");
            7'd17: return kw("TIME");     7'd18: return kw("LOMEM");
            7'd19: return kw("HIMEM");    7'd20: return kw("ABS");
            7'd21: return kw("ACS");      7'd22: return kw("ADVAL");
            7'd23: return kw("ASC");      7'd24: return kw("ASN");
            7'd25: return kw("ATN");      7'd26: return kw("BGET");
            7'd27: return kw("COS");      7'd28: return kw("COUNT");
            7'd29: return kw("DEG");      7'd30: return kw("ERL");
            7'd31: return kw("ERR");      7'd32: return kw("EVAL");
            7'd33: return kw("EXP");      7'd34: return kw("EXT");
            7'd35: return kw("FALSE");    7'd36: return kw("FN");
            7'd37: return kw("GET");      7'd38: return kw("INKEY");
            7'd39: return kw("INSTR(");   7'd40: return kw("INT");
            7'd41: return kw("LEN");      7'd42: return kw("LN");
            7'd43: return kw("LOG");      7'd44: return kw("NOT");
            7'd45: return kw("OPENUP");   7'd46: return kw("OPENOUT");
            7'd47: return kw("PI");       7'd48: return kw("POINT(");
            7'd49: return kw("POS");      7'd50: return kw("RAD");
            7'd51: return kw("RND");      7'd52: return kw("SGN");
            7'd53: return kw("SIN");      7'd54: return kw("SQR");
            7'd55: return kw("TAN");      7'd56: return kw("TO");
            7'd57: return kw("TRUE");     7'd58: return kw("USR");
            7'd59: return kw("VAL");      7'd60: return kw("VPOS");
            7'd61: return kw("CHR$");     7'd62: return kw("GET$");
            7'd63: return kw("INKEY$");   7'd64: return kw("LEFT$(");
            7'd65: return kw("MID$(");    7'd66: return kw("RIGHT$(");
            7'd67: return kw("STR$");     7'd68: return kw("STRING$(");
            7'd72: return kw("LIST");     7'd73: return kw("NEW");
            7'd74: return kw("OLD");      7'd75: return kw("RENUMBER");
            7'd76: return kw("SAVE");     7'd77: return kw("EDIT");
            7'd78: return kw("PUT");      7'd79: return kw("PTR");
            7'd80: return kw("PAGE");     7'd81: return kw("TIME");
            7'd82: return kw("LOMEM");    7'd83: return kw("HIMEM");
            7'd84: return kw("SOUND");    7'd85: return kw("BPUT");
            7'd86: return kw("CALL");     7'd87: return kw("CHAIN");
            7'd88: return kw("CLEAR");    7'd89: return kw("CLOSE");
            7'd90: return kw("CLG");      7'd91: return kw("CLS");
            7'd92: return kw("DATA");     7'd93: return kw("DEF");
            7'd94: return kw("DIM");      7'd95: return kw("DRAW");
            7'd96: return kw("END");      7'd97: return kw("ENDPROC");
            7'd98: return kw("ENVELOPE"); 7'd99: return kw("FOR");
            7'd100: return kw("GOSUB");   7'd101: return kw("GOTO");
            7'd102: return kw("GCOL");    7'd103: return kw("IF");
            7'd104: return kw("INPUT");   7'd105: return kw("LET");
            7'd106: return kw("LOCAL");   7'd107: return kw("MODE");
            7'd108: return kw("MOVE");    7'd109: return kw("NEXT");
            7'd110: return kw("ON");      7'd111: return kw("VDU");
            7'd112: return kw("PLOT");    7'd113: return kw("PRINT");
            7'd114: return kw("PROC");    7'd115: return kw("READ");
            7'd116: return kw("REM");     7'd117: return kw("REPEAT");
            7'd118: return kw("REPORT");  7'd119: return kw("RESTORE");
            7'd120: return kw("RETURN");  7'd121: return kw("RUN");
            7'd122: return kw("STOP");    7'd123: return kw("COLOUR");
            7'd124: return kw("TRACE");   7'd125: return kw("UNTIL");
            7'd126: return kw("WIDTH");   7'd127: return kw("OSCLI");
            default: return kw("");
        endcase
    endfunction

    function automatic t_kw esc_kw(input t_table sel, input logic [7:0] idx);
        case (sel)
            TBL_FN: begin
                case (idx)
                    8'd0: return kw("SUM");  8'd1: return kw("BEAT");
                    default: return kw("");
                endcase
            end
            TBL_CMD: begin
                case (idx)
                    8'd0: return kw("APPEND");    8'd1: return kw("AUTO");
                    8'd2: return kw("CRUNCH");    8'd3: return kw("DELET");
                    8'd4: return kw("EDIT");      8'd5: return kw("HELP");
                    8'd6: return kw("LIST");      8'd7: return kw("LOAD");
                    8'd8: return kw("LVAR");      8'd9: return kw("NEW");
                    8'd10: return kw("OLD");      8'd11: return kw("RENUMBER");
                    8'd12: return kw("SAVE");     8'd13: return kw("TEXTLOAD");
                    8'd14: return kw("TEXTSAVE"); 8'd15: return kw("TWIN");
                    8'd16: return kw("TWINO");    8'd17: return kw("INSTALL");
                    default: return kw("");
                endcase
            end
            TBL_STMT: begin
                case (idx)
                    8'd0: return kw("CASE");     8'd1: return kw("CIRCLE");
                    8'd2: return kw("FILL");     8'd3: return kw("ORIGIN");
                    8'd4: return kw("PSET");     8'd5: return kw("RECT");
                    8'd6: return kw("SWAP");     8'd7: return kw("WHILE");
                    8'd8: return kw("WAIT");     8'd9: return kw("MOUSE");
                    8'd10: return kw("QUIT");    8'd11: return kw("SYS");
                    8'd12: return kw("INSTALL"); 8'd13: return kw("LIBRARY");
                    8'd14: return kw("TINT");    8'd15: return kw("ELLIPSE");
                    8'd16: return kw("BEATS");   8'd17: return kw("TEMPO");
                    8'd18: return kw("VOICES");  8'd19: return kw("VOICE");
                    8'd20: return kw("STEREO");  8'd21: return kw("OVERLAY");
                    default: return kw("");
                endcase
            end
            default: return kw("");
        endcase
    endfunction

endpackage

FILE: sv/tokenized_basic_detokenizer_core.sv
// ----------------------------------------------------------------------------
// tokenized_basic_detokenizer_core: streaming BASIC program detokenizer
// Turns tokenized program bytes into text characters, one at a time.
// ----------------------------------------------------------------------------
// Input channel i_valid/o_ready carries one program byte per transaction.
// Output channel o_valid/i_ready carries one character per transaction with
// o_line_start on the first character of a line number and o_last on the
// final character caused by one input byte. A byte that produces nothing
// is absorbed in its accept cycle.
// Each input byte is accepted, then its characters go out one per output
// transaction: up to 8 for a keyword. The line number is first converted by a
// shared subtract-by-ten-power unit, one digit-step per cycle, then its 5
// characters stream out.
// The block is not ready while it converts or emits, so it takes no new byte
// until the last character of the previous byte has been emitted.
// When the receiver stalls, the current character holds in the text and digit
// registers and the sequencer waits. Reset returns the decoder to line data
// mode, main keyword table, no quoting, and drops any pending output.
// ----------------------------------------------------------------------------
module tokenized_basic_detokenizer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_char,
    output logic       o_line_start,
    output logic       o_last
);

    tbd_pkg::t_state r_state, n_state;
    tbd_pkg::t_mode  r_mode, n_mode;
    tbd_pkg::t_table r_table, n_table;
    logic        r_cnt, n_cnt;
    logic        r_quote, n_quote;
    logic [15:0] r_num, n_num;
    logic [15:0] r_rem, n_rem;
    logic [2:0]  r_pos, n_pos;      // digit position / char index
    logic [3:0]  r_dig, n_dig;
    logic [19:0] r_digits, n_digits;
    logic [63:0] r_text, n_text;
    logic [3:0]  r_len, n_len;
    logic        r_seen, n_seen;

    logic [15:0] pow10;
    logic [16:0] diff;
    tbd_pkg::t_kw look;
    logic [3:0]  d_cur;
    logic        accept, emit, shown;

    assign accept = i_valid && o_ready;
    assign o_ready = (r_state == tbd_pkg::ST_IDLE);
    assign emit = o_valid && i_ready;

    always_comb begin
        case (r_pos)
            3'd0:    pow10 = 16'd10000;
            3'd1:    pow10 = 16'd1000;
            3'd2:    pow10 = 16'd100;
            3'd3:    pow10 = 16'd10;
            default: pow10 = 16'd1;
        endcase
    end

    // shared subtractor for digit extraction
    assign diff = {1'b0, r_rem} - {1'b0, pow10};

    always_comb begin
        if (r_table == tbd_pkg::TBL_MAIN)
            look = tbd_pkg::main_kw(7'(i_in_byte - tbd_pkg::MAIN_BASE));
        else if (i_in_byte < tbd_pkg::ESC_BASE)
            look = '0;
        else
            look = tbd_pkg::esc_kw(r_table, i_in_byte - tbd_pkg::ESC_BASE);
    end

    assign d_cur = r_digits[19 - 4*r_pos -: 4];
    assign shown = r_seen || (d_cur != 4'd0) || (r_pos == 3'(tbd_pkg::NUM_WIDTH - 1));

    always_comb begin
        n_state = r_state; n_mode = r_mode; n_table = r_table; n_cnt = r_cnt;
        n_quote = r_quote; n_num = r_num; n_rem = r_rem; n_pos = r_pos;
        n_dig = r_dig; n_digits = r_digits; n_text = r_text; n_len = r_len;
        n_seen = r_seen;
        o_valid = 1'b0; o_out_char = 8'h00; o_line_start = 1'b0; o_last = 1'b0;
        case (r_state)
            tbd_pkg::ST_IDLE: begin
                if (accept) begin
                    case (r_mode)
                        tbd_pkg::MODE_NUMBER: begin
                            n_num = {r_num[7:0], i_in_byte};
                            n_cnt = ~r_cnt;
                            if (r_cnt) begin
                                n_mode  = tbd_pkg::MODE_LENGTH;
                                n_table = tbd_pkg::TBL_MAIN;
                            end
                        end
                        tbd_pkg::MODE_LENGTH: begin
                            n_mode = tbd_pkg::MODE_DATA;
                            n_rem = r_num; n_pos = '0; n_dig = '0;
                            n_state = tbd_pkg::ST_DIGITS;
                        end
                        default: begin
                            if (i_in_byte == tbd_pkg::BYTE_NEWLINE) begin
                                n_mode = tbd_pkg::MODE_NUMBER;
                                n_num = '0; n_cnt = 1'b0; n_quote = 1'b0;
                            end else if (i_in_byte == tbd_pkg::BYTE_LINENUM && !r_quote) begin
                                n_mode = r_mode;
                            end else begin
                                if (i_in_byte[7] && !r_quote &&
                                    i_in_byte != tbd_pkg::BYTE_QUOTE) begin
                                    if (i_in_byte == tbd_pkg::BYTE_ESC_FN)
                                        n_table = tbd_pkg::TBL_FN;
                                    else if (i_in_byte == tbd_pkg::BYTE_ESC_CMD)
                                        n_table = tbd_pkg::TBL_CMD;
                                    else if (i_in_byte == tbd_pkg::BYTE_ESC_STMT)
                                        n_table = tbd_pkg::TBL_STMT;
                                    else begin
                                        n_table = tbd_pkg::TBL_MAIN;
                                        n_text = look.text; n_len = look.len;
                                        n_pos = '0;
                                        if (look.len != 4'd0) n_state = tbd_pkg::ST_WORD;
                                    end
                                end else begin
                                    if (i_in_byte == tbd_pkg::BYTE_QUOTE) n_quote = ~r_quote;
                                    n_text = {i_in_byte, 56'd0}; n_len = 4'd1;
                                    n_pos = '0;
                                    n_state = tbd_pkg::ST_WORD;
                                end
                            end
                        end
                    endcase
                end
            end
            tbd_pkg::ST_DIGITS: begin
                if (!diff[16]) begin
                    n_rem = diff[15:0];
                    n_dig = r_dig + 4'd1;
                end else begin
                    n_digits[19 - 4*r_pos -: 4] = r_dig;
                    n_dig = '0;
                    if (r_pos == 3'(tbd_pkg::NUM_WIDTH - 1)) begin
                        n_pos = '0; n_seen = 1'b0;
                        n_state = tbd_pkg::ST_NUMBER;
                    end else begin
                        n_pos = r_pos + 3'd1;
                    end
                end
            end
            tbd_pkg::ST_NUMBER: begin
                o_valid = 1'b1;
                o_out_char = shown ? (8'h30 + {4'd0, d_cur}) : 8'h20;
                o_line_start = (r_pos == 3'd0);
                o_last = (r_pos == 3'(tbd_pkg::NUM_WIDTH - 1));
                if (emit) begin
                    n_seen = shown;
                    n_pos = r_pos + 3'd1;
                    if (o_last) n_state = tbd_pkg::ST_IDLE;
                end
            end
            default: begin
                o_valid = 1'b1;
                o_out_char = r_text[63 - 8*r_pos -: 8];
                o_last = ({1'b0, r_pos} == r_len - 4'd1);
                if (emit) begin
                    n_pos = r_pos + 3'd1;
                    if (o_last) n_state = tbd_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tbd_pkg::ST_IDLE;
            r_mode  <= tbd_pkg::MODE_DATA;
            r_table <= tbd_pkg::TBL_MAIN;
            r_cnt   <= 1'b0;
            r_quote <= 1'b0;
            r_num   <= '0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_table <= n_table;
            r_cnt   <= n_cnt;
            r_quote <= n_quote;
            r_num   <= n_num;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem; r_pos <= n_pos; r_dig <= n_dig; r_digits <= n_digits;
        r_text <= n_text; r_len <= n_len; r_seen <= n_seen;
    end

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != tbd_pkg::ST_IDLE) |-> !o_ready)
        else $error("accepted input while busy");
    a_start_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_line_start) |-> (r_state == tbd_pkg::ST_NUMBER && r_pos == 3'd0))
        else $error("line start off first number char");
    a_digit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tbd_pkg::ST_DIGITS) |-> (r_dig <= 4'd9))
        else $error("digit overflow");
    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_out_char)))
        else $error("output changed under stall");
`endif

endmodule
